// ===== sv/dht_pkg.sv =====
// shared types and constants for the ring lookup node
package dht_pkg;

	localparam int KEY_BITS_DEF     = 64;
	localparam int KEY_SLOTS_DEF    = 64;
	localparam int FINGER_SLOTS_DEF = 16;

	typedef enum logic [2:0] {
		V_FOUND  = 3'd0,
		V_SUCC   = 3'd1,
		V_FWD    = 3'd2,
		V_STORED = 3'd3,
		V_DUP    = 3'd4,
		V_SELF   = 3'd5,
		V_FULL   = 3'd6
	} verdict_t;

	typedef enum logic [1:0] {
		ACT_QUERY  = 2'd0,
		ACT_KEY    = 2'd1,
		ACT_FINGER = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_NODE = 2'd0,
		REG_PRED = 2'd1,
		REG_PKN  = 2'd2,
		REG_SUCC = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KSCAN,
		ST_FSCAN,
		ST_SHIFT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] key;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  verdict;
		logic [63:0] hop_node;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture the input transaction
		logic kclr;      // reset the scan index
		logic kstep;     // read/compare one entry
		logic kwrite;    // append key
		logic fstep;     // compare one finger
		logic fshift;    // shift one finger up
		logic fput;      // place finger, bump count
		logic fclear;    // empty finger table
		logic finish;    // produce result
	} dht_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] action;
		logic       kscan_end;
		logic       key_hit;
		logic       key_full;
		logic       fscan_end;
		logic       f_self;
		logic       f_dup;
		logic       f_full;
		logic       shift_end;
	} dht_sts_t;

endpackage

// ===== sv/dht_node_route_step_unit.sv =====
// top level of the ring lookup node: controller, datapath and configuration registers
// sequence from accept to result: insert key and clear pass the key scan state, then done
// query scans the stored keys until a match, else also scans the fingers for the hop
// insert finger scans the fingers, then shifts entries up and places it unless self, duplicate or full
// one transaction at a time, the next accepted while the result strobe is high; no result stall
// arst_n clears counts, configuration registers and the controller; tables are undefined until written
module dht_node_route_step_unit import dht_pkg::*; #(
	parameter int KEY_BITS     = KEY_BITS_DEF,
	parameter int KEY_SLOTS    = KEY_SLOTS_DEF,
	parameter int FINGER_SLOTS = FINGER_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    in_item,
	output logic        result_valid,
	output out_item_t   result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	dht_cmd_t    cmd;
	dht_sts_t    sts;
	logic [63:0] node_q, pred_q, succ_q;
	logic        pkn_q;

	// configuration registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= '0;
			pred_q <= '0;
			pkn_q  <= 1'b0;
			succ_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_NODE: node_q <= cfg_data;
				REG_PRED: pred_q <= cfg_data;
				REG_PKN:  pkn_q  <= cfg_data[0];
				REG_SUCC: succ_q <= cfg_data;
				default:  node_q <= node_q;
			endcase
		end
	end

	dht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	dht_dpath #(
		.KEY_BITS     (KEY_BITS),
		.KEY_SLOTS    (KEY_SLOTS),
		.FINGER_SLOTS (FINGER_SLOTS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (in_item),
		.node_id    (node_q),
		.pred_id    (pred_q),
		.pred_known (pkn_q),
		.succ_id    (succ_q),
		.cmd        (cmd),
		.sts        (sts),
		.done       (result_valid),
		.result     (result)
	);

`ifndef SYNTHESIS
	// a result strobe ends the transaction
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy) else $error("result while busy");
	// one strobe per transaction
	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("double result strobe");
`endif

endmodule

// ===== sv/dht_ctrl.sv =====
// controller state machine for the ring lookup node
module dht_ctrl import dht_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output dht_cmd_t cmd,
	input  dht_sts_t sts
);

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_n = ST_KSCAN;
			end
			ST_KSCAN: begin
				unique case (action_t'(sts.action))
					ACT_QUERY: begin
						// no stored match: walk the fingers for the hop
						priority if (sts.key_hit) state_n = ST_DONE;
						else if (sts.kscan_end) state_n = ST_FSCAN;
					end
					ACT_FINGER: state_n = ST_FSCAN;
					default:    state_n = ST_DONE;
				endcase
			end
			ST_FSCAN: begin
				if (action_t'(sts.action) == ACT_QUERY) begin
					if (sts.fscan_end) state_n = ST_DONE;
				end else if (sts.f_self || sts.f_dup || sts.fscan_end) begin
					state_n = (sts.f_self || sts.f_dup || sts.f_full) ? ST_DONE : ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (sts.shift_end) state_n = ST_DONE;
			end
			ST_DONE:  state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = start;
				cmd.kclr = start;
			end
			ST_KSCAN: begin
				unique case (action_t'(sts.action))
					ACT_QUERY:  cmd.kstep  = 1'b1;
					ACT_KEY:    cmd.kwrite = !sts.key_full;
					ACT_FINGER: cmd.kclr   = 1'b1;
					default:    cmd.fclear = 1'b1;
				endcase
			end
			ST_FSCAN: cmd.fstep = 1'b1;
			ST_SHIFT: begin
				cmd.fshift = !sts.shift_end;
				cmd.fput   = sts.shift_end;
			end
			ST_DONE:  cmd.finish = 1'b1;
			default:  cmd = '0;
		endcase
	end

endmodule

// ===== sv/dht_dpath.sv =====
// datapath: key memory, finger table, comparators and result register
module dht_dpath import dht_pkg::*; #(
	parameter int KEY_BITS     = KEY_BITS_DEF,
	parameter int KEY_SLOTS    = KEY_SLOTS_DEF,
	parameter int FINGER_SLOTS = FINGER_SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  in_item_t      item,
	input  logic [63:0]   node_id,
	input  logic [63:0]   pred_id,
	input  logic          pred_known,
	input  logic [63:0]   succ_id,
	input  dht_cmd_t      cmd,
	output dht_sts_t      sts,
	output logic          done,
	output out_item_t     result
);

	localparam int KAW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int KCW = $clog2(KEY_SLOTS + 1);
	localparam int FAW = (FINGER_SLOTS > 1) ? $clog2(FINGER_SLOTS) : 1;
	localparam int FCW = $clog2(FINGER_SLOTS + 1);

	logic [KEY_BITS-1:0] kmem [KEY_SLOTS];
	logic [KEY_BITS-1:0] fing_q [FINGER_SLOTS];
	logic [KEY_BITS-1:0] key_q, rd_q, pick_q;
	logic [1:0]          act_q;
	logic [KCW-1:0]      kcount_q, kidx_q;
	logic                rd_vld_q, hit_q;
	logic [FCW-1:0]      fcount_q, fidx_q;
	logic [2:0]          vcode;
	logic [KEY_BITS-1:0] me, pred, succ, hop;
	logic                in_iv;

	assign me   = node_id[KEY_BITS-1:0];
	assign pred = pred_id[KEY_BITS-1:0];
	assign succ = succ_id[KEY_BITS-1:0];

	// one key read per cycle, compared in the following cycle
	always_ff @(posedge clk) begin
		if (cmd.kwrite) kmem[kcount_q[KAW-1:0]] <= key_q;
		rd_q <= kmem[kidx_q[KAW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kcount_q <= '0;
			fcount_q <= '0;
			kidx_q   <= '0;
			fidx_q   <= '0;
			rd_vld_q <= 1'b0;
			hit_q    <= 1'b0;
			act_q    <= '0;
			done     <= 1'b0;
		end else begin
			done <= cmd.finish;
			if (cmd.load) begin
				act_q <= item.action;
				hit_q <= 1'b0;
			end
			if (cmd.kclr) begin
				kidx_q   <= '0;
				fidx_q   <= '0;
				rd_vld_q <= 1'b0;
			end
			if (cmd.kstep) begin
				rd_vld_q <= (kidx_q < kcount_q);
				if (kidx_q < kcount_q) kidx_q <= kidx_q + 1'b1;
				if (rd_vld_q && rd_q == key_q) hit_q <= 1'b1;
			end
			if (cmd.kwrite) kcount_q <= kcount_q + 1'b1;
			if (cmd.fclear) fcount_q <= '0;
			if (cmd.fstep) fidx_q <= sts.fscan_end ? fcount_q : fidx_q + 1'b1;
			if (cmd.fshift) fidx_q <= fidx_q - 1'b1;
			if (cmd.fput) fcount_q <= fcount_q + 1'b1;
		end
	end

	// finger storage; insertion shifts one entry per cycle from the top
	always_ff @(posedge clk) begin
		if (cmd.load) key_q <= item.key[KEY_BITS-1:0];
		if (cmd.fshift) fing_q[fidx_q[FAW-1:0]] <= fing_q[fidx_q[FAW-1:0] - FAW'(1)];
		if (cmd.fput) fing_q[fidx_q[FAW-1:0]] <= key_q;
		// greatest finger not above key, else first
		if (cmd.fstep && fidx_q < fcount_q) begin
			if (fidx_q == '0 || fing_q[fidx_q[FAW-1:0]] <= key_q)
				pick_q <= fing_q[fidx_q[FAW-1:0]];
		end
	end

	always_comb begin
		sts.action    = act_q;
		sts.kscan_end = cmd.kstep && !rd_vld_q && (kidx_q >= kcount_q) && !hit_q;
		sts.key_hit   = hit_q || (rd_vld_q && rd_q == key_q);
		sts.key_full  = (kcount_q >= KCW'(KEY_SLOTS));
		sts.fscan_end = (fidx_q >= fcount_q);
		sts.f_self    = (key_q == me) && (act_q == ACT_FINGER);
		sts.f_dup     = (fidx_q < fcount_q) && (fing_q[fidx_q[FAW-1:0]] == key_q);
		sts.f_full    = (fcount_q >= FCW'(FINGER_SLOTS));
		sts.shift_end = (fidx_q == '0) || !(fing_q[fidx_q[FAW-1:0] - FAW'(1)] > key_q);
	end

	// ring-interval test and hop choice
	always_comb begin
		in_iv = !pred_known
			|| (key_q <= me && key_q > pred)
			|| (key_q > me && key_q > pred && pred > me)
			|| (key_q <= me && pred > me);
		priority if (in_iv) hop = me;
		else if (me > succ || fcount_q == '0) hop = succ;
		else hop = pick_q;
	end

	// finish-time verdict
	always_comb begin
		vcode = V_STORED;
		unique case (action_t'(act_q))
			ACT_QUERY: begin
				priority if (hit_q) vcode = V_FOUND;
				else if (key_q <= me) vcode = V_SUCC;
				else vcode = V_FWD;
			end
			default:    vcode = V_STORED;
		endcase
	end

	logic [2:0] fv_q;
	always_ff @(posedge clk) begin
		if (cmd.load) fv_q <= V_STORED;
		if (cmd.kstep == 1'b0 && act_q == ACT_KEY && cmd.kwrite == 1'b0 && !cmd.load
			&& !cmd.finish && !done && sts.key_full) fv_q <= V_FULL;
		if (cmd.fstep) begin
			priority if (sts.f_self) fv_q <= V_SELF;
			else if (sts.f_dup) fv_q <= V_DUP;
			else if (sts.fscan_end && sts.f_full) fv_q <= V_FULL;
			else fv_q <= V_STORED;
		end
		if (cmd.finish) begin
			result.verdict  <= (act_q == ACT_QUERY) ? vcode
				: (act_q == ACT_CLEAR) ? V_STORED : fv_q;
			result.hop_node <= (act_q == ACT_QUERY && vcode == V_FWD)
				? 64'(hop) : 64'd0;
		end
	end

endmodule
